### src/kfc_pkg.sv
// Shared types, codes and constants of the keepalive failover controller.
package kfc_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int IVL_W       = 16;
    localparam int SIL_W       = 17;
    localparam int TRY_W       = 3;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CNT_W-1:0] SERVER_COUNT_RESET = 5'd1;
    localparam logic [IDX_W-1:0] START_SERVER_RESET = 4'd0;
    localparam logic [IVL_W-1:0] MIN_INTERVAL_RESET = 16'd3;
    localparam logic [IVL_W-1:0] MAX_INTERVAL_RESET = 16'd300;
    localparam logic [IVL_W-1:0] TIMEOUT_DEFAULT    = 16'd600;
    localparam logic [IVL_W-1:0] INTERVAL_RESET     = 16'd3;
    localparam logic [TRY_W-1:0] UDP_TRIES          = 3'd6;
    localparam logic [TRY_W-1:0] HTTP_TRIES         = 3'd3;

    typedef enum logic [2:0] {
        ACT_START   = 3'd0,
        ACT_TIMER   = 3'd1,
        ACT_RESPOND = 3'd2,
        ACT_KICKOUT = 3'd3,
        ACT_STOP    = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        KIND_CONNECT = 3'd0,
        KIND_SEND    = 3'd1,
        KIND_STATUS  = 3'd2,
        KIND_LEAVE   = 3'd3,
        KIND_NONE    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_NOSERVER = 3'd2,
        ST_ALLUSED  = 3'd3,
        ST_KICKOUT  = 3'd4,
        ST_REFUSED  = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SERVER_COUNT  = 3'd0,
        CFG_START_SERVER  = 3'd1,
        CFG_MIN_INTERVAL  = 3'd2,
        CFG_MAX_INTERVAL  = 3'd3,
        CFG_TIMEOUT_LIMIT = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [CNT_W-1:0] server_count;
        logic [IDX_W-1:0] start_server;
        logic [IVL_W-1:0] min_interval;
        logic [IVL_W-1:0] max_interval;
        logic [IVL_W-1:0] timeout_limit;
    } cfg_t;

    typedef struct packed {
        action_t          action;
        logic [7:0]       pass_state;
        logic [IVL_W-1:0] offered_interval;
        logic             identity_match;
    } in_item_t;

    typedef struct packed {
        kind_t            result_kind;
        logic [IDX_W-1:0] server_index;
        logic             use_http;
        status_t          status_code;
        logic [7:0]       refusal_code;
        logic [IVL_W-1:0] current_interval;
        logic             last;
    } result_t;

endpackage

### src/keepalive_failover_controller.sv
// Flow: an item is registered on acceptance; its results go to the registered output stage.
// Throughput: one item per cycle while m_tready is high and each item gives
// at most one result; a timer expiry that reconnects gives two results and holds
// the event logic until the single result port takes the second one from the two-slot output register.
// Reset: synchronous, active-low aresetn restores the register defaults and idle session state.
module keepalive_failover_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // pass_state, offered_interval, identity_match
    input  logic [2:0]                    s_tuser,  // action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,  // server_index, use_http, status_code,
                                                    // refusal_code, current_interval
    output logic [2:0]                    m_tuser,  // result_kind
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);

    logic              in_valid_reg, in_valid_next;
    kfc_pkg::in_item_t in_item_reg, in_item_next;
    logic              fire;
    logic              out_free;
    logic [1:0]        res_count;
    kfc_pkg::result_t  res0, res1;
    kfc_pkg::result_t  m_item;
    kfc_pkg::cfg_t     cfg;

    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_tready) begin
            in_valid_next                 = s_tvalid;
            in_item_next.action           = kfc_pkg::action_t'(s_tuser);
            in_item_next.pass_state       = s_tdata[7:0];
            in_item_next.offered_interval = s_tdata[23:8];
            in_item_next.identity_match   = s_tdata[24];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        in_item_reg <= in_item_next;
    end

    assign cfg_ready = 1'b1;

    kfc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kfc_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (in_item_reg),
        .cfg       (cfg),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    kfc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1),
        .free      (out_free),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_item    (m_item)
    );

    assign m_tuser = m_item.result_kind;
    assign m_tlast = m_item.last;
    assign m_tdata = {m_item.current_interval, m_item.refusal_code, m_item.status_code,
                      m_item.use_http, m_item.server_index};

endmodule

### src/kfc_cfg_regs.sv
// Configuration register bank of the keepalive failover controller.
module kfc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [kfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kfc_pkg::IVL_W-1:0]     cfg_data,
    output kfc_pkg::cfg_t                 cfg
);

    kfc_pkg::cfg_t cfg_reg;
    kfc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (kfc_pkg::cfg_index_t'(cfg_index))
                kfc_pkg::CFG_SERVER_COUNT:
                    cfg_next.server_count = cfg_data[kfc_pkg::CNT_W-1:0];
                kfc_pkg::CFG_START_SERVER:
                    cfg_next.start_server = cfg_data[kfc_pkg::IDX_W-1:0];
                kfc_pkg::CFG_MIN_INTERVAL:  cfg_next.min_interval  = cfg_data;
                kfc_pkg::CFG_MAX_INTERVAL:  cfg_next.max_interval  = cfg_data;
                kfc_pkg::CFG_TIMEOUT_LIMIT: cfg_next.timeout_limit = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.server_count  <= kfc_pkg::SERVER_COUNT_RESET;
            cfg_reg.start_server  <= kfc_pkg::START_SERVER_RESET;
            cfg_reg.min_interval  <= kfc_pkg::MIN_INTERVAL_RESET;
            cfg_reg.max_interval  <= kfc_pkg::MAX_INTERVAL_RESET;
            cfg_reg.timeout_limit <= kfc_pkg::TIMEOUT_DEFAULT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/kfc_engine.sv
// Session state and the event logic that produces up to two results per item.
module kfc_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  kfc_pkg::in_item_t item,
    input  kfc_pkg::cfg_t     cfg,
    output logic [1:0]        res_count,
    output kfc_pkg::result_t  res0,
    output kfc_pkg::result_t  res1
);

    logic                        running_reg, running_next;
    logic                        ever_reg, ever_next;
    logic                        fra_reg, fra_next;
    logic                        http_reg, http_next;
    logic [kfc_pkg::TRY_W-1:0]   retries_reg, retries_next;
    logic [kfc_pkg::SIL_W-1:0]   silent_reg, silent_next;
    logic [kfc_pkg::IVL_W-1:0]   interval_reg, interval_next;
    logic [kfc_pkg::IDX_W-1:0]   first_reg, first_next;
    logic [kfc_pkg::IDX_W-1:0]   cur_reg, cur_next;
    kfc_pkg::status_t            latch_reg, latch_next;

    logic [kfc_pkg::CNT_W-1:0]   n_eff;
    logic [kfc_pkg::TRY_W-1:0]   tries_now;
    logic [kfc_pkg::IDX_W-1:0]   step_idx;
    logic [kfc_pkg::IDX_W-1:0]   ns_idx;
    logic                        ns_fra;
    kfc_pkg::status_t            ns_err;
    kfc_pkg::status_t            err;
    logic [kfc_pkg::TRY_W-1:0]   r;
    logic [kfc_pkg::IVL_W-1:0]   lo, hi;
    kfc_pkg::kind_t              k0, k1;
    kfc_pkg::status_t            st0;
    logic [7:0]                  ref0;
    logic [1:0]                  cnt;

    assign n_eff = (cfg.server_count > kfc_pkg::CNT_W'(kfc_pkg::MAX_SERVERS))
                 ? kfc_pkg::CNT_W'(kfc_pkg::MAX_SERVERS) : cfg.server_count;
    assign tries_now = http_reg ? kfc_pkg::HTTP_TRIES : kfc_pkg::UDP_TRIES;
    assign step_idx  = (({1'b0, cur_reg} + 5'd1) >= n_eff)
                     ? '0 : cur_reg + kfc_pkg::IDX_W'(1);

    // One step round the server ring; a full lap without any answer gives up,
    // after an answer the first server of the lap is tried once more before giving up.
    always_comb begin
        ns_idx = cur_reg;
        ns_fra = fra_reg;
        ns_err = kfc_pkg::ST_OK;
        if (fra_reg) begin
            ns_err = kfc_pkg::ST_ALLUSED;
        end else begin
            ns_idx = step_idx;
            if (step_idx == first_reg) begin
                if (!ever_reg) ns_err = kfc_pkg::ST_ALLUSED;
                else           ns_fra = 1'b1;
            end
        end
    end

    always_comb begin
        running_next  = running_reg;
        ever_next     = ever_reg;
        fra_next      = fra_reg;
        http_next     = http_reg;
        retries_next  = retries_reg;
        silent_next   = silent_reg;
        interval_next = interval_reg;
        first_next    = first_reg;
        cur_next      = cur_reg;
        latch_next    = latch_reg;
        err  = kfc_pkg::ST_OK;
        r    = retries_reg;
        lo   = (cfg.min_interval == '0) ? kfc_pkg::IVL_W'(1) : cfg.min_interval;
        hi   = (cfg.max_interval == '0) ? kfc_pkg::IVL_W'(1) : cfg.max_interval;
        k0   = kfc_pkg::KIND_NONE;
        k1   = kfc_pkg::KIND_NONE;
        st0  = kfc_pkg::ST_OK;
        ref0 = '0;
        cnt  = 2'd0;
        case (item.action)
            kfc_pkg::ACT_START: begin
                latch_next  = kfc_pkg::ST_OK;
                silent_next = '0;
                fra_next    = 1'b0;
                if (ever_reg) begin
                    retries_next = tries_now;
                end else begin
                    http_next    = 1'b0;
                    retries_next = kfc_pkg::HTTP_TRIES;
                end
                if (n_eff == '0) begin
                    running_next = 1'b0;
                    k0  = kfc_pkg::KIND_STATUS;
                    st0 = kfc_pkg::ST_NOSERVER;
                    cnt = 2'd1;
                end else begin
                    first_next   = ({1'b0, cfg.start_server} < n_eff) ? cfg.start_server : '0;
                    cur_next     = first_next;
                    silent_next  = {1'b0, interval_reg};
                    running_next = 1'b1;
                    k0  = kfc_pkg::KIND_CONNECT;
                    cnt = 2'd1;
                end
            end
            kfc_pkg::ACT_TIMER: begin
                if (running_reg && latch_reg == kfc_pkg::ST_OK) begin
                    if (silent_reg >= {1'b0, cfg.timeout_limit}) begin
                        err = kfc_pkg::ST_TIMEOUT;
                    end else begin
                        if (retries_reg == '0) begin
                            if (!ever_reg) begin
                                if (!http_reg) begin
                                    http_next = 1'b1;
                                end else begin
                                    err      = ns_err;
                                    cur_next = ns_idx;
                                    fra_next = ns_fra;
                                    if (ns_err == kfc_pkg::ST_OK) http_next = 1'b0;
                                end
                                r = kfc_pkg::HTTP_TRIES;
                            end else begin
                                err      = ns_err;
                                cur_next = ns_idx;
                                fra_next = ns_fra;
                                if (ns_err == kfc_pkg::ST_OK) r = tries_now;
                            end
                            if (err == kfc_pkg::ST_OK) begin
                                k0  = kfc_pkg::KIND_CONNECT;
                                k1  = kfc_pkg::KIND_SEND;
                                cnt = 2'd2;
                            end
                        end else begin
                            k0  = kfc_pkg::KIND_SEND;
                            cnt = 2'd1;
                        end
                        if (err == kfc_pkg::ST_OK) r = r - kfc_pkg::TRY_W'(1);
                        retries_next = r;
                    end
                    if (err != kfc_pkg::ST_OK) begin
                        latch_next   = err;
                        running_next = 1'b0;
                        k0  = kfc_pkg::KIND_STATUS;
                        st0 = err;
                        cnt = 2'd1;
                    end else begin
                        silent_next = silent_reg + {1'b0, interval_reg};
                    end
                end
            end
            kfc_pkg::ACT_RESPOND: begin
                if (running_reg) begin
                    ever_next    = 1'b1;
                    first_next   = cur_reg;
                    fra_next     = 1'b0;
                    retries_next = tries_now;
                    silent_next  = '0;
                    k0  = kfc_pkg::KIND_STATUS;
                    cnt = 2'd1;
                    if (item.pass_state == '0) begin
                        // lo is checked first; if bounds cross, below lo gets lo, else hi.
                        if (item.offered_interval < lo)      interval_next = lo;
                        else if (item.offered_interval > hi) interval_next = hi;
                        else                                 interval_next = item.offered_interval;
                        st0 = latch_reg;
                    end else begin
                        latch_next   = kfc_pkg::ST_REFUSED;
                        running_next = 1'b0;
                        st0  = kfc_pkg::ST_REFUSED;
                        ref0 = item.pass_state;
                    end
                end
            end
            kfc_pkg::ACT_KICKOUT: begin
                if (running_reg && item.identity_match) begin
                    latch_next   = kfc_pkg::ST_KICKOUT;
                    running_next = 1'b0;
                    k0  = kfc_pkg::KIND_STATUS;
                    st0 = kfc_pkg::ST_KICKOUT;
                    cnt = 2'd1;
                end
            end
            kfc_pkg::ACT_STOP: begin
                if (running_reg) begin
                    running_next = 1'b0;
                    k0  = kfc_pkg::KIND_LEAVE;
                    cnt = 2'd1;
                end
            end
            default: ;
        endcase
    end

    // All results of one item see the state as it stands after that item.
    always_comb begin
        res0.result_kind      = k0;
        res0.server_index     = cur_next;
        res0.use_http         = http_next;
        res0.status_code      = st0;
        res0.refusal_code     = ref0;
        res0.current_interval = interval_next;
        res0.last             = (cnt == 2'd1);
        res1.result_kind      = k1;
        res1.server_index     = cur_next;
        res1.use_http         = http_next;
        res1.status_code      = kfc_pkg::ST_OK;
        res1.refusal_code     = '0;
        res1.current_interval = interval_next;
        res1.last             = 1'b1;
    end

    assign res_count = cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg  <= 1'b0;
            ever_reg     <= 1'b0;
            fra_reg      <= 1'b0;
            http_reg     <= 1'b0;
            retries_reg  <= '0;
            silent_reg   <= '0;
            interval_reg <= kfc_pkg::INTERVAL_RESET;
            first_reg    <= '0;
            cur_reg      <= '0;
            latch_reg    <= kfc_pkg::ST_OK;
        end else if (fire) begin
            running_reg  <= running_next;
            ever_reg     <= ever_next;
            fra_reg      <= fra_next;
            http_reg     <= http_next;
            retries_reg  <= retries_next;
            silent_reg   <= silent_next;
            interval_reg <= interval_next;
            first_reg    <= first_next;
            cur_reg      <= cur_next;
            latch_reg    <= latch_next;
        end
    end

endmodule

### src/kfc_out_stage.sv
// Two-slot result register that presents the results of one item in order.
module kfc_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  logic [1:0]       res_count,
    input  kfc_pkg::result_t res0,
    input  kfc_pkg::result_t res1,
    output logic             free,
    output logic             m_valid,
    input  logic             m_ready,
    output kfc_pkg::result_t m_item
);

    logic             a_valid_reg, a_valid_next;
    logic             b_valid_reg, b_valid_next;
    kfc_pkg::result_t a_reg, a_next;
    kfc_pkg::result_t b_reg, b_next;

    // New results may load when no result is presented, or once it leaves and nothing waits behind it.
    assign free = !a_valid_reg || (m_ready && !b_valid_reg);

    always_comb begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        if (fire) begin
            a_valid_next = (res_count != 2'd0);
            b_valid_next = (res_count == 2'd2);
            a_next       = res0;
            b_next       = res1;
        end else if (a_valid_reg && m_ready) begin
            a_valid_next = b_valid_reg;
            b_valid_next = 1'b0;
            a_next       = b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign m_valid = a_valid_reg;
    assign m_item  = a_reg;

endmodule
